// ===== rtl/bpc_pkg.sv =====
// Shared types, phase codes and defaults for the button press count entry block.
package bpc_pkg;

  localparam int COUNT_MAX_DEF = 255;
  localparam int TIME_BITS_DEF = 16;

  localparam int CNT_W   = 8;
  localparam int PHASE_W = 3;
  localparam int DEB_W   = 8;
  localparam int LIM_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_REL = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_PRS = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FIRST_DB = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COUNTING = 3'd4;
  localparam logic [PHASE_W-1:0] PH_COUNT_DB = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FINAL    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 2'd3;

  localparam logic [DEB_W-1:0] DEB_MAX = 8'd255;

  typedef struct packed {
    logic             active_low;
    logic [DEB_W-1:0] debounce_ticks;
    logic [LIM_W-1:0] window_ticks;
    logic [LIM_W-1:0] idle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [CNT_W-1:0]   count;
    logic [DEB_W-1:0]   debounce;
    logic               was_pressed;
  } ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0]   press_count;
    logic [PHASE_W-1:0] phase;
    logic               locked;
    logic               done_res;
  } res_t;

endpackage

// ===== rtl/bpc_cfg.sv =====
// Configuration register file for the button press count entry block.
module bpc_cfg
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_LOW: cfg_nxt.active_low     = cfg_data[0];
        REG_DEBOUNCE:   cfg_nxt.debounce_ticks = cfg_data[DEB_W-1:0];
        REG_WINDOW:     cfg_nxt.window_ticks   = cfg_data[LIM_W-1:0];
        REG_IDLE:       cfg_nxt.idle_ticks     = cfg_data[LIM_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low     <= 1'b1;
      cfg_r.debounce_ticks <= 8'd4;
      cfg_r.window_ticks   <= 16'd1000;
      cfg_r.idle_ticks     <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bpc_step.sv =====
// Per-beat next-state logic: phase sequencing, debounce, window and idle timers.
module bpc_step
  import bpc_pkg::*;
#(
  parameter int COUNT_MAX = COUNT_MAX_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
)(
  input  cfg_t                 cfg,
  input  ctl_t                 ctl,
  input  logic [TIME_BITS-1:0] elapsed,
  input  logic [TIME_BITS-1:0] idle,
  input  logic                 func,
  input  logic                 raw_level,
  output ctl_t                 ctl_nxt,
  output logic [TIME_BITS-1:0] elapsed_nxt,
  output logic [TIME_BITS-1:0] idle_nxt,
  output res_t                 res
);

  localparam int CMP_W = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [CMP_W-1:0] TIME_MAX_W = CMP_W'(TIME_MAX);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNT_MAX);

  logic             pressed;
  logic [DEB_W-1:0] dmin;
  logic [CMP_W-1:0] win_lim;
  logic [CMP_W-1:0] idl_lim;
  logic [TIME_BITS-1:0] el_inc;
  logic [TIME_BITS-1:0] id_inc;
  logic [DEB_W-1:0] db_inc;
  logic             win_hit;
  logic             idl_hit;
  logic             lock;
  logic             done;

  // Effective limits: zero acts as one, anything above the timer range clamps.
  always_comb begin
    win_lim = (cfg.window_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.window_ticks);
    if (win_lim > TIME_MAX_W) win_lim = TIME_MAX_W;
    idl_lim = (cfg.idle_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.idle_ticks);
    if (idl_lim > TIME_MAX_W) idl_lim = TIME_MAX_W;
  end

  assign pressed = cfg.active_low ? ~raw_level : raw_level;
  assign dmin    = (cfg.debounce_ticks == '0) ? DEB_W'(1) : cfg.debounce_ticks;
  assign el_inc  = (elapsed == TIME_MAX) ? elapsed : elapsed + TIME_BITS'(1);
  assign id_inc  = (idle == TIME_MAX) ? idle : idle + TIME_BITS'(1);
  assign db_inc  = (ctl.debounce == DEB_MAX) ? ctl.debounce : ctl.debounce + DEB_W'(1);
  assign win_hit = CMP_W'(el_inc) >= win_lim;
  assign idl_hit = CMP_W'(id_inc) >= idl_lim;

  always_comb begin
    ctl_nxt     = ctl;
    elapsed_nxt = elapsed;
    idle_nxt    = idle;
    lock        = 1'b0;
    done        = 1'b0;
    if (func) begin
      ctl_nxt.count       = '0;
      ctl_nxt.debounce    = '0;
      ctl_nxt.was_pressed = 1'b0;
      ctl_nxt.phase       = PH_WAIT_REL;
      elapsed_nxt         = '0;
      idle_nxt            = '0;
    end else begin
      case (ctl.phase)
        PH_WAIT_REL: begin
          if (!pressed) ctl_nxt.phase = PH_WAIT_PRS;
        end
        PH_WAIT_PRS: begin
          if (pressed) begin
            ctl_nxt.debounce = '0;
            ctl_nxt.phase    = PH_FIRST_DB;
          end
        end
        PH_FIRST_DB: begin
          ctl_nxt.debounce = db_inc;
          if (db_inc >= dmin) begin
            if (pressed) begin
              ctl_nxt.count       = CNT_W'(1);
              ctl_nxt.was_pressed = 1'b1;
              elapsed_nxt         = '0;
              idle_nxt            = '0;
              ctl_nxt.phase       = PH_COUNTING;
            end else begin
              ctl_nxt.phase = PH_WAIT_PRS;
            end
          end
        end
        PH_COUNTING: begin
          // an idle lock skips the window tick
          if (!pressed && idl_hit) begin
            ctl_nxt.was_pressed = 1'b0;
            idle_nxt            = id_inc;
            lock                = 1'b1;
          end else begin
            if (pressed && !ctl.was_pressed) begin
              ctl_nxt.debounce = '0;
              ctl_nxt.phase    = PH_COUNT_DB;
            end else if (!pressed) begin
              ctl_nxt.was_pressed = 1'b0;
              idle_nxt            = id_inc;
            end else begin
              idle_nxt = '0;
            end
            elapsed_nxt = el_inc;
            lock        = win_hit;
          end
        end
        PH_COUNT_DB: begin
          ctl_nxt.debounce = db_inc;
          elapsed_nxt      = el_inc;
          if (db_inc >= dmin) begin
            if (win_hit) begin
              lock = 1'b1;
            end else begin
              if (pressed) begin
                if (ctl.count < CNT_TOP) ctl_nxt.count = ctl.count + CNT_W'(1);
                ctl_nxt.was_pressed = 1'b1;
                idle_nxt            = '0;
              end
              ctl_nxt.phase = PH_COUNTING;
            end
          end
        end
        PH_FINAL: begin
          if (!pressed) begin
            done          = 1'b1;
            ctl_nxt.phase = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (lock) begin
        if (ctl_nxt.count == '0) ctl_nxt.count = CNT_W'(1);
        ctl_nxt.phase = PH_FINAL;
      end
    end
  end

  assign res.press_count = ctl_nxt.count;
  assign res.phase       = ctl_nxt.phase;
  assign res.locked      = lock;
  assign res.done_res    = done;

endmodule

// ===== rtl/button_press_count_entry.sv =====
// Top level of the button press count entry block: beat registers, state and checks.
//
// Usage: each input beat is either a start command (in_func = 1) or one poll
// tick (in_func = 0) carrying the raw pin level in in_raw_level. Every input
// beat gives exactly one output beat: the press count, the phase after the
// beat, a one-beat locked pulse (drive the beeper from it) and a one-beat
// done_res pulse when the key is released after locking.
// A beat accepted on in_valid is registered at the input, the update runs on
// the registered beat, and the result is held in the output register.
// Throughput: one beat per cycle while out_stall is low; the state update is a
// single pass of compare/increment logic between the input and output registers.
// Stall: while out_stall holds a pending result, the output register keeps it,
// one more beat can wait in the input register, and then in_stall rises.
// Reset clears both beat registers, the state (phase idle, count zero) and
// loads the register defaults: active low, debounce 4, window 1000, idle 300.
// Configuration beats on cfg_ are always taken (cfg_ready stays high) and are
// to be written only while no tick is in flight.
module button_press_count_entry
  import bpc_pkg::*;
#(
  parameter int COUNT_MAX = COUNT_MAX_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic                  in_raw_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CNT_W-1:0]      out_press_count,
  output logic [PHASE_W-1:0]    out_phase,
  output logic                  out_locked,
  output logic                  out_done_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic in_vld_r;
  logic func_r;
  logic raw_r;
  logic out_vld_r;
  res_t res_r;
  res_t res_nxt;
  ctl_t ctl_r;
  ctl_t ctl_nxt;
  logic [TIME_BITS-1:0] elapsed_r;
  logic [TIME_BITS-1:0] elapsed_nxt;
  logic [TIME_BITS-1:0] idle_r;
  logic [TIME_BITS-1:0] idle_nxt;
  logic out_take;
  logic in_take;

  assign cfg_ready = 1'b1;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_step #(
    .COUNT_MAX (COUNT_MAX),
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg         (cfg),
    .ctl         (ctl_r),
    .elapsed     (elapsed_r),
    .idle        (idle_r),
    .func        (func_r),
    .raw_level   (raw_r),
    .ctl_nxt     (ctl_nxt),
    .elapsed_nxt (elapsed_nxt),
    .idle_nxt    (idle_nxt),
    .res         (res_nxt)
  );

  // output register frees up when empty or when its beat is taken
  assign out_take = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !out_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ctl_r     <= '0;
      elapsed_r <= '0;
      idle_r    <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (out_take) begin
        in_vld_r <= 1'b0;
      end
      if (out_take) begin
        out_vld_r <= 1'b1;
        ctl_r     <= ctl_nxt;
        elapsed_r <= elapsed_nxt;
        idle_r    <= idle_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_func;
      raw_r  <= in_raw_level;
    end
    if (out_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_press_count = res_r.press_count;
  assign out_phase       = res_r.phase;
  assign out_locked      = res_r.locked;
  assign out_done_res    = res_r.done_res;

  a_lock_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.locked |-> res_r.phase == PH_FINAL && res_r.press_count != '0)
    else $error("lock beat without final phase or with zero count");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.done_res |-> res_r.phase == PH_IDLE && !res_r.locked)
    else $error("done beat not in idle phase");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_take |=> $stable(ctl_r) && $stable(elapsed_r) && $stable(idle_r))
    else $error("state changed without a beat moving to the output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !in_vld_r)
    else $error("beat registers not empty after reset");

endmodule
